/* rtl/edm_pkg.sv */
package edm_pkg;

   localparam int COORD_BITS = 16;
   localparam int ACC_BITS   = 37;
   localparam int LEN_BITS   = 20;

   // root of an ACC_BITS radicand, taken one bit pair per step
   localparam int ROOT_BITS  = (ACC_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;

   localparam int STEP_MAX   = (ROOT_BITS > COORD_BITS) ? ROOT_BITS : COORD_BITS;
   localparam int CNT_BITS   = $clog2(STEP_MAX);

   localparam logic METRIC_EUCLID    = 1'b0;
   localparam logic METRIC_MANHATTAN = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_ACC  = 5'b00100,
      S_ROOT = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

endpackage

/* rtl/edge_distance_euclid_manhattan.sv */
// Channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// req      | req_valid/req_stall | first_coord, second_coord (Q8.8), last_dim
// rsp      | rsp_valid/rsp_stall | length (Q12.8, 20b), overflow
// csr      | csr_wr_en           | csr_wr_data = metric (0 euclid, 1 manhattan)
//
// A Euclidean item runs accept, 16 steps of the serial shift-add multiplier
// and accumulate; a Manhattan item runs accept and accumulate. A last item
// adds 19 bit-pair square root steps (Euclidean only) and an output state.
// Reset is synchronous, clears metric, accumulator, flag and control state.
// The result sits in an output register; the next item is taken while it
// waits, and only a second result stalls behind a stalled rsp side.
module edge_distance_euclid_manhattan
   import edm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COORD_BITS-1:0] req_first_coord,
   input  logic signed [COORD_BITS-1:0] req_second_coord,
   input  logic                        req_last_dim,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [LEN_BITS-1:0]         rsp_length,
   output logic                        rsp_overflow
);

   state_type                 state_ff, state_in;
   logic                      metric_ff, metric_in;     // csr register
   logic                      imetric_ff, imetric_in;   // metric of item in flight
   logic                      last_ff, last_in;
   logic [COORD_BITS-1:0]     diff_ff, diff_in;
   logic [2*COORD_BITS-1:0]   prod_ff, prod_in;         // {hi, multiplier shift}
   logic [ACC_BITS-1:0]       acc_ff, acc_in;
   logic                      sat_ff, sat_in;
   logic [RAD_BITS-1:0]       rad_ff, rad_in;           // radicand shift register
   logic [REM_BITS-1:0]       rem_ff, rem_in;
   logic [ROOT_BITS-1:0]      root_ff, root_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LEN_BITS-1:0]       rsp_length_ff, rsp_length_in;
   logic                      rsp_overflow_ff, rsp_overflow_in;

   // datapath temporaries
   logic [COORD_BITS-1:0]     a_u, b_u, diff_new;
   logic [COORD_BITS:0]       mul_sum;
   logic [ACC_BITS:0]         term_ext, acc_sum;
   logic [ACC_BITS-1:0]       acc_new;
   logic [REM_BITS+1:0]       rem_sh, trial, rem_diff;
   logic                      out_free, len_clamp;
   logic [LEN_BITS-1:0]       len_val;

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_overflow = rsp_overflow_ff;

   always_comb begin
      // offset binary keeps the ordering of the signed coordinates
      a_u      = {~req_first_coord[COORD_BITS-1],  req_first_coord[COORD_BITS-2:0]};
      b_u      = {~req_second_coord[COORD_BITS-1], req_second_coord[COORD_BITS-2:0]};
      diff_new = (a_u >= b_u) ? (a_u - b_u) : (b_u - a_u);

      // shift-add step: add multiplicand to the high half when lsb set
      mul_sum  = {1'b0, prod_ff[2*COORD_BITS-1:COORD_BITS]}
               + (prod_ff[0] ? {1'b0, diff_ff} : {(COORD_BITS+1){1'b0}});

      // saturating accumulate
      if (imetric_ff == METRIC_MANHATTAN) begin
         term_ext = {{(ACC_BITS+1-COORD_BITS){1'b0}}, diff_ff};
      end else begin
         term_ext = {{(ACC_BITS+1-2*COORD_BITS){1'b0}}, prod_ff};
      end
      acc_sum  = {1'b0, acc_ff} + term_ext;
      acc_new  = acc_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : acc_sum[ACC_BITS-1:0];

      // one restoring root step: bring down two radicand bits, try 4q+1
      rem_sh   = {rem_ff, rad_ff[RAD_BITS-1 -: 2]};
      trial    = {{(REM_BITS-ROOT_BITS){1'b0}}, root_ff, 2'b01};
      rem_diff = rem_sh - trial;

      // final length
      len_clamp = (|acc_ff[ACC_BITS-1:LEN_BITS]);
      if (imetric_ff == METRIC_MANHATTAN) begin
         len_val = len_clamp ? {LEN_BITS{1'b1}} : acc_ff[LEN_BITS-1:0];
      end else begin
         len_val = {{(LEN_BITS-ROOT_BITS){1'b0}}, root_ff};
      end

      out_free = !rsp_valid_ff || !rsp_stall;

      state_in        = state_ff;
      metric_in       = csr_wr_en ? csr_wr_data : metric_ff;
      imetric_in      = imetric_ff;
      last_in         = last_ff;
      diff_in         = diff_ff;
      prod_in         = prod_ff;
      acc_in          = acc_ff;
      sat_in          = sat_ff;
      rad_in          = rad_ff;
      rem_in          = rem_ff;
      root_in         = root_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_length_in   = rsp_length_ff;
      rsp_overflow_in = rsp_overflow_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               diff_in    = diff_new;
               last_in    = req_last_dim;
               imetric_in = metric_ff;
               prod_in    = {{COORD_BITS{1'b0}}, diff_new};
               cnt_in     = CNT_BITS'(COORD_BITS - 1);
               state_in   = (metric_ff == METRIC_MANHATTAN) ? S_ACC : S_MUL;
            end
         end
         S_MUL: begin
            prod_in = {mul_sum, prod_ff[COORD_BITS-1:1]};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_in = acc_new;
            if (acc_sum[ACC_BITS]) begin
               sat_in = 1'b1;
            end
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (imetric_ff == METRIC_EUCLID) begin
               rad_in   = {{(RAD_BITS-ACC_BITS){1'b0}}, acc_new};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CNT_BITS'(ROOT_BITS - 1);
               state_in = S_ROOT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_ROOT: begin
            rad_in = {rad_ff[RAD_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_diff[REM_BITS-1:0];
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[REM_BITS-1:0];
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_length_in   = len_val;
               rsp_overflow_in = sat_ff
                               || ((imetric_ff == METRIC_MANHATTAN) && len_clamp);
               acc_in          = '0;
               sat_in          = 1'b0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         metric_ff    <= METRIC_EUCLID;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         metric_ff    <= metric_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      imetric_ff      <= imetric_in;
      last_ff         <= last_in;
      diff_ff         <= diff_in;
      prod_ff         <= prod_in;
      rad_ff          <= rad_in;
      rem_ff          <= rem_in;
      root_ff         <= root_in;
      cnt_ff          <= cnt_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

endmodule

/* dv/edm_length_checker.sv */
module edm_length_checker
   import edm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_first_coord,
   input  logic signed [COORD_BITS-1:0] req_second_coord,
   input  logic                         req_last_dim,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [LEN_BITS-1:0]          rsp_length,
   input  logic                         rsp_overflow,
   output int                           fail_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [LEN_BITS-1:0] length;
      logic                overflow;
   } edge_len_type;

   localparam logic [ACC_BITS-1:0] ACC_FULL = '1;
   localparam logic [ACC_BITS-1:0] LEN_FULL = {{(ACC_BITS-LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}};

   logic                metric;
   logic [ACC_BITS-1:0] run_sum;
   logic                run_sat;
   edge_len_type        due_lengths[$];
   int                  errors = 0;

   // floor root, built MSB first by trial squaring
   function automatic logic [ACC_BITS-1:0] root_floor(input logic [ACC_BITS-1:0] v);
      logic [ROOT_BITS-1:0] r;
      logic [ROOT_BITS-1:0] cand;
      logic [RAD_BITS-1:0]  sq;
      r = '0;
      for (int k = ROOT_BITS - 1; k >= 0; k--) begin
         cand = r | (ROOT_BITS'(1) << k);
         sq   = RAD_BITS'(cand) * RAD_BITS'(cand);
         if (sq <= RAD_BITS'(v))
            r = cand;
      end
      return ACC_BITS'(r);
   endfunction

   task automatic note_mismatch(input string what, input longint want, input longint got);
      errors++;
      if (errors <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   task automatic fold_dimension(input logic signed [COORD_BITS-1:0] a,
                                 input logic signed [COORD_BITS-1:0] b,
                                 input logic                         last_mark);
      logic signed [COORD_BITS:0] delta;
      logic [COORD_BITS-1:0]      mag;
      logic [ACC_BITS-1:0]        term;
      logic [ACC_BITS:0]          total;
      logic [ACC_BITS-1:0]        span;
      edge_len_type               want;
      delta = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
      mag   = delta[COORD_BITS] ? COORD_BITS'(-delta) : delta[COORD_BITS-1:0];
      term  = ACC_BITS'(mag);
      if (metric == METRIC_EUCLID)
         term = term * term;
      total = {1'b0, run_sum} + {1'b0, term};
      if (total > {1'b0, ACC_FULL}) begin
         run_sum = ACC_FULL;
         run_sat = 1'b1;
      end else begin
         run_sum = total[ACC_BITS-1:0];
      end
      if (last_mark) begin
         span          = (metric == METRIC_EUCLID) ? root_floor(run_sum) : run_sum;
         want.overflow = run_sat;
         if (span > LEN_FULL) begin
            span          = LEN_FULL;
            want.overflow = 1'b1;
         end
         want.length = span[LEN_BITS-1:0];
         due_lengths.push_back(want);
         run_sum = '0;
         run_sat = 1'b0;
      end
   endtask

   task automatic match_length(input logic [LEN_BITS-1:0] got_len, input logic got_ovf);
      edge_len_type want;
      if (due_lengths.size() == 0) begin
         note_mismatch("unexpected result, length", -1, longint'(got_len));
      end else begin
         want = due_lengths.pop_front();
         if (want.length !== got_len)
            note_mismatch("length", longint'(want.length), longint'(got_len));
         if (want.overflow !== got_ovf)
            note_mismatch("overflow", longint'(want.overflow), longint'(got_ovf));
      end
   endtask

   // all inputs and outputs change only on NBAs, so pre-edge values are read here
   always @(posedge clock) begin
      if (reset) begin
         metric  = METRIC_EUCLID;
         run_sum = '0;
         run_sat = 1'b0;
         due_lengths.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            match_length(rsp_length, rsp_overflow);
         if (csr_wr_en)
            metric = csr_wr_data;
         if (req_valid && !req_stall)
            fold_dimension(req_first_coord, req_second_coord, req_last_dim);
      end
      fail_count  <= errors;
      outstanding <= due_lengths.size();
   end

endmodule

/* dv/tb_edge_distance_euclid_manhattan.sv */
module tb_edge_distance_euclid_manhattan;
   timeunit 1ns;
   timeprecision 1ps;
   import edm_pkg::*;

   localparam int HOLD_CYCLES   = 300;  // long receiver hold-off, fills the block
   localparam int SETTLE_CYCLES = 48;   // euclid item, root and output, with margin
   localparam int ITEM_TARGET   = 700;
   localparam int PHASES        = 8;
   localparam int DIM_MAX       = 16;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         csr_wr_en        = 1'b0;
   logic                         csr_wr_data      = 1'b0;
   logic                         req_valid        = 1'b0;
   logic                         req_stall;
   logic signed [COORD_BITS-1:0] req_first_coord  = '0;
   logic signed [COORD_BITS-1:0] req_second_coord = '0;
   logic                         req_last_dim     = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall        = 1'b0;
   logic [LEN_BITS-1:0]          rsp_length;
   logic                         rsp_overflow;

   int   fail_count;
   int   outstanding;
   int   sent     = 0;     // accepted input items
   logic idle_on  = 1'b1;  // off: both sides run back to back
   logic hold_rsp = 1'b0;  // stimulus asks the receiver for one long hold-off

   always #2 clock = ~clock;

   edge_distance_euclid_manhattan DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_coord  (req_first_coord),
      .req_second_coord (req_second_coord),
      .req_last_dim     (req_last_dim),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_length       (rsp_length),
      .rsp_overflow     (rsp_overflow)
   );

   edm_length_checker edge_len_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_coord  (req_first_coord),
      .req_second_coord (req_second_coord),
      .req_last_dim     (req_last_dim),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_length       (rsp_length),
      .rsp_overflow     (rsp_overflow),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // Gap length shared by both sides: half none, most of the rest short, a few long.
   function automatic int gap_len();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mix of rails, values near zero and the full range (covers every bit).
   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      logic [31:0] r;
      r = $urandom();
      case (r[31:29])
         3'd0:       return 16'sh7FFF;
         3'd1:       return 16'sh8000;
         3'd2, 3'd3: return {{7{r[8]}}, r[8:0]};   // within +-1.0
         default:    return r[15:0];
      endcase
   endfunction

   // One dimension item. Called at a rising edge; returns at the edge that took
   // the item, with valid still high so a follow-on item can go back to back.
   task automatic send_dim(input logic signed [COORD_BITS-1:0] a,
                           input logic signed [COORD_BITS-1:0] b,
                           input logic                         last_mark);
      int pause;
      pause = gap_len();
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_first_coord  <= a;
      req_second_coord <= b;
      req_last_dim     <= last_mark;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // A point pair: random coordinates, sometimes equal (zero difference).
   task automatic send_pair(input int dims);
      logic signed [COORD_BITS-1:0] a;
      logic signed [COORD_BITS-1:0] b;
      for (int k = 0; k < dims; k++) begin
         a = rand_coord();
         b = ($urandom_range(0, 7) == 0) ? a : rand_coord();
         send_dim(a, b, k == dims - 1);
      end
   endtask

   // Drop valid, wait for every expected length, then let a half-done
   // euclid multiply (item with no result) run out before touching the csr.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_metric(input logic sel);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sel;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Receiver pacing: open and stalled stretches, plus one long hold on request.
   initial begin : rsp_pacing
      int run;
      @(posedge clock);
      forever begin
         rsp_stall <= 1'b0;
         run = gap_len() + 1;
         repeat (run) @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            run = gap_len();
            if (run > 0) begin
               rsp_stall <= 1'b1;
               repeat (run) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int   long_dims;
      logic sel;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed: euclid ----
      write_metric(METRIC_EUCLID);
      send_dim(16'sh0000, 16'sh0000, 1'b1);   // zero length
      send_dim(16'sh7FFF, 16'sh8000, 1'b1);   // widest difference, root 65535
      send_dim(16'sh8000, 16'sh7FFF, 1'b1);   // same, other direction
      send_dim(16'sh0100, 16'sh0000, 1'b0);   // 1.0, 1.0, 3.0 over three dims
      send_dim(16'sh0000, 16'sh0100, 1'b0);
      send_dim(16'sh0300, 16'sh0000, 1'b1);
      send_dim(-16'sd1,   16'sd1,    1'b1);   // straddles zero
      send_dim(16'sh0005, 16'sh0005, 1'b1);   // equal coordinates
      // metric switched mid-pair: squared term first, then an absolute one
      send_dim(16'sh0300, 16'sh0000, 1'b0);
      wait_quiet();
      write_metric(METRIC_MANHATTAN);
      send_dim(16'sh0000, 16'sh0400, 1'b1);

      // ---- directed: manhattan ----
      send_dim(16'sh7FFF, 16'sh8000, 1'b1);
      send_dim(16'sh8000, 16'sh8000, 1'b1);
      send_dim(16'sh0123, -16'sh0456, 1'b0);
      send_dim(16'sh7FFF, 16'sh7FFF, 1'b1);
      // and back: absolute term first, root taken at the end
      send_dim(16'sh0064, -16'sh0064, 1'b0);
      wait_quiet();
      write_metric(METRIC_EUCLID);
      send_dim(16'sh0000, 16'sh0010, 1'b1);

      // ---- random phases, alternating metric, last two random ----
      for (int phase = 0; phase < PHASES; phase++) begin
         // sender pauses until every length is back before each csr write
         wait_quiet();
         sel = (phase < PHASES - 2) ? ((phase % 2 == 0) ? METRIC_EUCLID : METRIC_MANHATTAN)
                                    : logic'($urandom_range(0, 1));
         write_metric(sel);
         idle_on = (phase != 3 && phase != 6);

         // Rails-to-rails pairs around the limits: euclid 34 dims saturates
         // the accumulator, 32 just fits; manhattan 17 dims clamps the length,
         // 16 just fits. The first three run past the nominal dimension count.
         if (phase < 4) begin
            case (phase)
               0:       long_dims = 34;
               1:       long_dims = 17;
               2:       long_dims = 32;
               default: long_dims = 16;
            endcase
            for (int k = 0; k < long_dims; k++)
               send_dim((k % 2) ? 16'sh7FFF : 16'sh8000,
                        (k % 2) ? 16'sh8000 : 16'sh7FFF, k == long_dims - 1);
         end

         // Receiver holds off while single-dim pairs keep coming: the output
         // register fills, then the block stalls its input.
         if (phase == 4) begin
            hold_rsp = 1'b1;
            repeat (30) send_pair(1);
         end

         while (sent < (phase + 1) * (ITEM_TARGET / PHASES))
            send_pair(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, DIM_MAX + 4));
      end

      wait_quiet();
      if (fail_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin : watchdog
      #3ms;
      $display("Verification failed");
      $finish;
   end

endmodule
